// File: rtl/assert_macros.svh
// Assertion macros included by the executor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on clk, disabled during reset.
`define CK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent assertion on clk, active during reset as well.
`define CK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/c8x_pkg.sv
// Package: shared constants and types of the CHIP-8 executor.
`timescale 1ns / 1ps
package c8x_pkg;
  localparam int MEM_BYTES_DEF   = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam logic [11:0] START_RESET = 12'h200;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNK    = 2'd1;
  localparam logic [1:0] ST_STACK  = 2'd2;
  localparam logic [1:0] ST_HALTED = 2'd3;

  localparam logic [7:0] KK_CLS = 8'hE0;
  localparam logic [7:0] KK_RET = 8'hEE;
  localparam logic [7:0] KK_GDT = 8'h07;
  localparam logic [7:0] KK_SDT = 8'h15;
  localparam logic [7:0] KK_SST = 8'h18;
  localparam logic [7:0] KK_ADI = 8'h1E;
  localparam logic [7:0] KK_FNT = 8'h29;
  localparam logic [7:0] KK_BCD = 8'h33;
  localparam logic [7:0] KK_LDM = 8'h65;

  // ALU operations
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,  // a + b
    ALU_EQ  = 3'd1,  // a == b
    ALU_SUB = 3'd2,  // a - b, flag set when no borrow
    ALU_AND = 3'd3   // a & b
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [15:0] a;
    logic [15:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] y;
    logic        flag;  // equal, or no borrow for subtract
  } alu_rsp_t;
endpackage

// File: rtl/c8x_alu.sv
// Shared 16-bit add, compare, subtract and AND unit.
`timescale 1ns / 1ps
module c8x_alu (
  input  c8x_pkg::alu_req_t req,
  output c8x_pkg::alu_rsp_t rsp
);
  import c8x_pkg::*;
  logic [16:0] diff;
  always_comb begin
    diff = {1'b0, req.a} - {1'b0, req.b};
    rsp  = '0;
    unique case (req.op)
      ALU_ADD: rsp.y = req.a + req.b;
      ALU_EQ:  rsp.flag = (req.a == req.b);
      ALU_SUB: begin
        rsp.y    = diff[15:0];
        rsp.flag = !diff[16];
      end
      ALU_AND: rsp.y = req.a & req.b;
      default: rsp = '0;
    endcase
  end
endmodule

// File: rtl/chip8_instruction_executor.sv
// Top level: CHIP-8 executor with memory, registers, sequencer and shared ALU.
//
// Usage:
//   Input channel in_*: a request is taken when in_valid is high and
//   in_stall is low. Command 0 writes mem_data to mem_address; command 1
//   fetches the opcode at pc and executes it. One result request follows
//   each input on out_*, held until out_stall is low.
//   Configuration: cfg_valid/cfg_ready write start_address, which also
//   loads pc. Write only while the block is idle.
// Sequencing:
//   One request at a time; in_stall is high from acceptance until the
//   result is taken. A memory write or a halted request goes straight to
//   S_OUT; an opcode passes S_F0, S_F1, S_F2, S_EXEC, S_EXEC2, S_TIMER and
//   S_OUT. BCD adds S_BCD/S_BCDW steps (digits by repeated subtract in the
//   shared ALU), and block load adds one S_LDR/S_LDW pair per register read
//   from the single-port memory. The result is held on out_* while
//   out_stall is high.
// Reset: pc = 0x200, registers, timers, stack pointer cleared, not halted.
//   Memory and return stack hold no reset value.
// Receiver stall: the result stays on out_* and no new request is taken.
`timescale 1ns / 1ps
module chip8_instruction_executor #(
  parameter int MEMORY_BYTES = c8x_pkg::MEM_BYTES_DEF,
  parameter int STACK_DEPTH  = c8x_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [11:0] in_mem_address,
  input  logic [7:0]  in_mem_data,
  input  logic [7:0]  in_random_bits,
  input  logic [3:0]  in_view_register,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_executed_opcode,
  output logic [11:0] out_program_counter,
  output logic [15:0] out_index_value,
  output logic [4:0]  out_stack_level,
  output logic [7:0]  out_delay_value,
  output logic [7:0]  out_sound_value,
  output logic [7:0]  out_register_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_start_address
);
  import c8x_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_F0    = 12'b000000000010,  // read high byte
    S_F1    = 12'b000000000100,  // latch high, read low
    S_F2    = 12'b000000001000,  // latch low
    S_EXEC  = 12'b000000010000,  // decode, first ALU use
    S_EXEC2 = 12'b000000100000,  // second ALU use (pc advance)
    S_BCD   = 12'b000001000000,  // digit by repeated subtract
    S_BCDW  = 12'b000010000000,  // write one digit
    S_LDR   = 12'b000100000000,  // block load read
    S_LDW   = 12'b001000000000,  // block load register write
    S_TIMER = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  mem [MEMORY_BYTES];
  logic [7:0]  mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_a;
  logic [7:0]  mem_d;

  logic [11:0] ret_stk [STACK_DEPTH];
  logic [7:0]  gr_r [16];

  logic [11:0] pc_r;
  logic [15:0] idx_r, op_r;
  logic [7:0]  dt_r, st_r;
  logic [SW:0] sp_r;
  logic        halt_r;
  logic [1:0]  stat_r;
  logic [7:0]  rnd_r;
  logic [3:0]  view_r;
  logic [7:0]  work_r;   // BCD remainder
  logic [7:0]  dig_r;    // current digit count
  logic [1:0]  dsel_r;   // digit index
  logic [3:0]  cnt_r;    // block load and BCD address counter
  logic [11:0] pcadd_r;  // pc + 1 fetch address, then amount to add in EXEC2

  alu_req_t areq;
  alu_rsp_t arsp;
  c8x_alu u_alu (.req(areq), .rsp(arsp));

  logic [3:0] op_x, op_y, op_hi;
  logic [7:0] op_kk, vx, vy;
  assign op_hi = op_r[15:12];
  assign op_x  = op_r[11:8];
  assign op_y  = op_r[7:4];
  assign op_kk = op_r[7:0];
  assign vx    = gr_r[op_x];
  assign vy    = gr_r[op_y];

  logic [7:0] bcd_div;
  always_comb begin
    case (dsel_r)
      2'd0:    bcd_div = 8'd100;
      2'd1:    bcd_div = 8'd10;
      default: bcd_div = 8'd1;
    endcase
  end

  logic [15:0] ld_addr;
  assign ld_addr = idx_r + {12'd0, cnt_r};

  // memory port
  always_comb begin
    mem_we = 1'b0;
    mem_a  = pc_r[AW-1:0];
    mem_d  = in_mem_data;
    if (state_r == S_IDLE) begin
      mem_we = in_valid && !in_command;
      mem_a  = in_mem_address[AW-1:0];
    end else if (state_r == S_F1) begin
      mem_a = pcadd_r[AW-1:0];
    end else if (state_r == S_BCDW) begin
      mem_we = 1'b1;
      mem_a  = ld_addr[AW-1:0];
      mem_d  = dig_r;
    end else if (state_r == S_LDR) begin
      mem_a = ld_addr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_d;
    mem_q <= mem[mem_a];
  end

  // ALU request
  always_comb begin
    areq = '{op: ALU_ADD, a: 16'd0, b: 16'd0};
    unique case (state_r)
      S_F0:    areq = '{op: ALU_ADD, a: {4'd0, pc_r}, b: 16'd1};
      S_EXEC: begin
        unique case (op_hi) inside
          4'h3, 4'h4: areq = '{op: ALU_EQ, a: {8'd0, vx}, b: {8'd0, op_kk}};
          4'h5:       areq = '{op: ALU_EQ, a: {8'd0, vx}, b: {8'd0, vy}};
          4'h7:       areq = '{op: ALU_ADD, a: {8'd0, vx}, b: {8'd0, op_kk}};
          4'hB:       areq = '{op: ALU_ADD, a: {4'd0, op_r[11:0]}, b: {8'd0, gr_r[0]}};
          4'hC:       areq = '{op: ALU_AND, a: {8'd0, rnd_r}, b: {8'd0, op_kk}};
          4'h0:       areq = '{op: ALU_ADD, a: {4'd0, ret_stk[sp_r[SW-1:0] - 1'b1]},
                               b: 16'd2};
          4'hF: begin
            if (op_kk == KK_ADI) areq = '{op: ALU_ADD, a: idx_r, b: {8'd0, vx}};
            else areq = '{op: ALU_ADD, a: {8'd0, vx}, b: {6'd0, vx, 2'd0}};
          end
          default: areq = '{op: ALU_ADD, a: 16'd0, b: 16'd0};
        endcase
      end
      S_EXEC2: areq = '{op: ALU_ADD, a: {4'd0, pc_r}, b: {4'd0, pcadd_r}};
      S_BCD:   areq = '{op: ALU_SUB, a: {8'd0, work_r}, b: {8'd0, bcd_div}};
      S_BCDW:  areq = '{op: ALU_ADD, a: {8'd0, dig_r}, b: 16'd0};
      S_TIMER: areq = '{op: ALU_SUB, a: {8'd0, dt_r}, b: 16'd1};
      default: areq = '{op: ALU_ADD, a: 16'd0, b: 16'd0};
    endcase
  end

  logic f_known;
  always_comb begin
    unique case (op_kk) inside
      KK_GDT, KK_SDT, KK_SST, KK_ADI, KK_FNT, KK_BCD, KK_LDM: f_known = 1'b1;
      default: f_known = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = (in_command && !halt_r) ? S_F0 : S_OUT;
      S_F0:    state_nxt = S_F1;
      S_F1:    state_nxt = S_F2;
      S_F2:    state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_EXEC2;
      S_EXEC2: begin
        if (stat_r == ST_OK && op_hi == 4'hF && op_kk == KK_BCD) state_nxt = S_BCD;
        else if (stat_r == ST_OK && op_hi == 4'hF && op_kk == KK_LDM) state_nxt = S_LDR;
        else state_nxt = S_TIMER;
      end
      S_BCD:   if (!arsp.flag || dsel_r == 2'd2) state_nxt = S_BCDW;
      S_BCDW:  state_nxt = (dsel_r == 2'd2) ? S_TIMER : S_BCD;
      S_LDR:   state_nxt = S_LDW;
      S_LDW:   state_nxt = (cnt_r == op_x) ? S_TIMER : S_LDR;
      S_TIMER: state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= START_RESET;
      idx_r   <= '0;
      dt_r    <= '0;
      st_r    <= '0;
      sp_r    <= '0;
      halt_r  <= 1'b0;
      for (int i = 0; i < 16; i++) gr_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        pc_r <= cfg_start_address;
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          rnd_r  <= in_random_bits;
          view_r <= in_view_register;
          op_r   <= '0;
          stat_r <= halt_r ? ST_HALTED : ST_OK;
        end
        S_F0: pcadd_r <= arsp.y[11:0];
        S_F1: op_r[15:8] <= mem_q;
        S_F2: op_r[7:0] <= mem_q;
        S_EXEC: begin
          pcadd_r <= 12'd2;
          unique case (op_hi) inside
            4'h0: begin
              if (op_x == 4'd0 && op_kk == KK_CLS) ;
              else if (op_x == 4'd0 && op_kk == KK_RET) begin
                if (sp_r == '0) begin
                  stat_r <= ST_STACK; pcadd_r <= 12'd0;
                end else begin
                  sp_r <= sp_r - 1'b1; pc_r <= arsp.y[11:0]; pcadd_r <= 12'd0;
                end
              end else begin
                stat_r <= ST_UNK; pcadd_r <= 12'd0;
              end
            end
            4'h1: begin pc_r <= op_r[11:0]; pcadd_r <= 12'd0; end
            4'h2: begin
              pcadd_r <= 12'd0;
              if (sp_r >= (SW+1)'(STACK_DEPTH)) stat_r <= ST_STACK;
              else begin
                ret_stk[sp_r[SW-1:0]] <= pc_r;
                sp_r <= sp_r + 1'b1;
                pc_r <= op_r[11:0];
              end
            end
            4'h3, 4'h5: pcadd_r <= arsp.flag ? 12'd4 : 12'd2;
            4'h4: pcadd_r <= arsp.flag ? 12'd2 : 12'd4;
            4'h6: gr_r[op_x] <= op_kk;
            4'h7, 4'hC: gr_r[op_x] <= arsp.y[7:0];
            4'hA: idx_r <= {4'd0, op_r[11:0]};
            4'hB: begin pc_r <= arsp.y[11:0]; pcadd_r <= 12'd0; end
            4'hD: ;
            4'hF: begin
              if (!f_known) begin
                stat_r <= ST_UNK; pcadd_r <= 12'd0;
              end else begin
                unique case (op_kk) inside
                  KK_GDT: gr_r[op_x] <= dt_r;
                  KK_SDT: dt_r <= vx;
                  KK_SST: st_r <= vx;
                  KK_ADI, KK_FNT: idx_r <= arsp.y;
                  default: ;
                endcase
              end
            end
            default: begin stat_r <= ST_UNK; pcadd_r <= 12'd0; end
          endcase
          work_r <= vx;
          dig_r  <= '0;
          dsel_r <= '0;
          cnt_r  <= '0;
        end
        S_EXEC2: begin
          pc_r <= arsp.y[11:0];
          if (stat_r != ST_OK) halt_r <= 1'b1;
        end
        S_BCD: begin
          if (arsp.flag && dsel_r != 2'd2) begin
            work_r <= arsp.y[7:0];
            dig_r  <= dig_r + 1'b1;
          end else if (dsel_r == 2'd2) dig_r <= work_r;
        end
        S_BCDW: begin
          dsel_r <= dsel_r + 1'b1;
          cnt_r  <= cnt_r + 1'b1;
          dig_r  <= '0;
        end
        S_LDW: begin
          gr_r[cnt_r] <= mem_q;
          cnt_r <= cnt_r + 1'b1;
        end
        S_TIMER: if (arsp.flag) dt_r <= arsp.y[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign out_valid = (state_r == S_OUT);
  assign out_status          = stat_r;
  assign out_executed_opcode = op_r;
  assign out_program_counter = pc_r;
  assign out_index_value     = idx_r;
  assign out_stack_level     = 5'(sp_r);
  assign out_delay_value     = dt_r;
  assign out_sound_value     = st_r;
  assign out_register_value  = gr_r[view_r];

  `CK_ASSERT(a_sp_range, sp_r <= (SW+1)'(STACK_DEPTH), "stack pointer out of range")
  `CK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_status),
             "result dropped under stall")
  `CK_ASSERT(a_halted_stat, out_valid && halt_r && $past(state_r) == S_IDLE |->
             out_status == ST_HALTED, "halted request not reported")
  `CK_ASSERT_ALWAYS(a_busy, state_r != S_IDLE |-> in_stall, "taken while busy")
endmodule

// File: dv/testbench.sv
// Testbench for chip8_instruction_executor: generated programs checked against a behavioral model.
`timescale 1ns / 1ps
module testbench;
  import c8x_pkg::*;

  // Command codes on the input channel
  localparam bit CMD_WRITE = 1'b0;
  localparam bit CMD_EXEC  = 1'b1;

  // Opcode groups (top nibble)
  localparam bit [3:0] OP_SYS  = 4'h0;
  localparam bit [3:0] OP_JP   = 4'h1;
  localparam bit [3:0] OP_CALL = 4'h2;
  localparam bit [3:0] OP_SEI  = 4'h3;
  localparam bit [3:0] OP_SNEI = 4'h4;
  localparam bit [3:0] OP_SER  = 4'h5;
  localparam bit [3:0] OP_LDI  = 4'h6;
  localparam bit [3:0] OP_ADDI = 4'h7;
  localparam bit [3:0] OP_ALU  = 4'h8;
  localparam bit [3:0] OP_SNER = 4'h9;
  localparam bit [3:0] OP_LDIX = 4'hA;
  localparam bit [3:0] OP_JPV0 = 4'hB;
  localparam bit [3:0] OP_RND  = 4'hC;
  localparam bit [3:0] OP_DRW  = 4'hD;
  localparam bit [3:0] OP_KEY  = 4'hE;
  localparam bit [3:0] OP_MISC = 4'hF;

  localparam int MEM_SIZE  = 4096;
  localparam int STK_DEPTH = 16;
  localparam int IDLE_PCT  = 27;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN     = 60;

  typedef struct {
    bit        cmd;
    bit [11:0] addr;
    bit [7:0]  data;
    bit [7:0]  rnd;
    bit [3:0]  view;
  } cpu_req_t;

  typedef struct {
    bit [1:0]  status;
    bit [15:0] op;
    bit [11:0] pc;
    bit [15:0] ix;
    bit [4:0]  sp;
    bit [7:0]  dt;
    bit [7:0]  st;
    bit [7:0]  rv;
  } cpu_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [11:0] in_mem_address = '0;
  logic [7:0]  in_mem_data = '0;
  logic [7:0]  in_random_bits = '0;
  logic [3:0]  in_view_register = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_executed_opcode;
  logic [11:0] out_program_counter;
  logic [15:0] out_index_value;
  logic [4:0]  out_stack_level;
  logic [7:0]  out_delay_value;
  logic [7:0]  out_sound_value;
  logic [7:0]  out_register_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_start_address = '0;

  chip8_instruction_executor dut (.*);

  // Request and result queues. Expected results are worked out as requests
  // are queued; the block handles them strictly in order so this is exact.
  cpu_req_t   req_q[$];
  cpu_state_t expected_q[$];
  int         errors = 0;

  // Traffic shaping knobs, driven by the sequence
  bit quiet = 1'b0;      // no random idling on either side
  bit hold_go = 1'b0;    // request one long receiver hold-off
  int hold_cnt = 0;

  // Shadow machine state
  bit [7:0]  mem_img[MEM_SIZE];
  bit        mem_written[MEM_SIZE];
  bit [7:0]  vreg[16];
  bit [11:0] ret_stack[STK_DEPTH];
  int        sp;
  bit [11:0] pc;
  bit [15:0] ix;
  bit [7:0]  dtimer;
  bit [7:0]  stimer;
  bit        halted;

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------
  function automatic void mem_store(bit [15:0] a, bit [7:0] d);
    mem_img[a[11:0]] = d;
    mem_written[a[11:0]] = 1'b1;
  endfunction

  // Executes one opcode on the shadow state, returns the step status.
  function automatic bit [1:0] execute(bit [15:0] op, bit [7:0] rnd);
    bit [3:0]  x = op[11:8];
    bit [3:0]  y = op[7:4];
    bit [7:0]  kk = op[7:0];
    bit [11:0] nnn = op[11:0];
    bit [7:0]  vx = vreg[op[11:8]];
    case (op[15:12])
      OP_SYS: begin
        if (x == 4'h0 && kk == KK_CLS) begin
          pc += 12'd2;
        end else if (x == 4'h0 && kk == KK_RET) begin
          if (sp == 0) return ST_STACK;
          sp--;
          pc = ret_stack[sp] + 12'd2;
        end else begin
          return ST_UNK;
        end
      end
      OP_JP: pc = nnn;
      OP_CALL: begin
        if (sp >= STK_DEPTH) return ST_STACK;
        ret_stack[sp] = pc;
        sp++;
        pc = nnn;
      end
      OP_SEI:  pc += (vx == kk) ? 12'd4 : 12'd2;
      OP_SNEI: pc += (vx != kk) ? 12'd4 : 12'd2;
      OP_SER:  pc += (vx == vreg[y]) ? 12'd4 : 12'd2;  // low nibble ignored
      OP_LDI: begin
        vreg[x] = kk;
        pc += 12'd2;
      end
      OP_ADDI: begin
        vreg[x] = vx + kk;
        pc += 12'd2;
      end
      OP_LDIX: begin
        ix = {4'h0, nnn};
        pc += 12'd2;
      end
      OP_JPV0: pc = nnn + {4'h0, vreg[0]};
      OP_RND: begin
        vreg[x] = rnd & kk;
        pc += 12'd2;
      end
      OP_DRW: pc += 12'd2;
      OP_MISC: begin
        case (kk)
          KK_GDT: vreg[x] = dtimer;
          KK_SDT: dtimer = vx;
          KK_SST: stimer = vx;
          KK_ADI: ix = ix + {8'h00, vx};
          KK_FNT: ix = {8'h00, vx} * 16'd5;
          KK_BCD: begin
            mem_store(ix, 8'(vx / 100));
            mem_store(ix + 16'd1, 8'((vx / 10) % 10));
            mem_store(ix + 16'd2, 8'(vx % 10));
          end
          KK_LDM: begin
            for (int i = 0; i <= x; i++) vreg[i] = mem_img[12'(ix + 16'(i))];
          end
          default: return ST_UNK;
        endcase
        pc += 12'd2;
      end
      default: return ST_UNK;
    endcase
    return ST_OK;
  endfunction

  function automatic cpu_state_t predict_step(cpu_req_t r);
    cpu_state_t res;
    res.op = '0;
    if (r.cmd == CMD_WRITE) begin
      mem_store({4'h0, r.addr}, r.data);
      res.status = halted ? ST_HALTED : ST_OK;
    end else if (halted) begin
      res.status = ST_HALTED;
    end else begin
      res.op = {mem_img[pc], mem_img[pc + 12'd1]};
      res.status = execute(res.op, r.rnd);
      if (res.status != ST_OK) halted = 1'b1;
      if (dtimer != 0) dtimer--;
    end
    res.pc = pc;
    res.ix = ix;
    res.sp = 5'(sp);
    res.dt = dtimer;
    res.st = stimer;
    res.rv = vreg[r.view];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------
  task automatic send(bit cmd, bit [11:0] addr, bit [7:0] data);
    cpu_req_t r;
    r.cmd = cmd;
    r.addr = addr;
    r.data = data;
    r.rnd = 8'($urandom);
    r.view = 4'($urandom);
    req_q = {req_q, r};
    expected_q = {expected_q, predict_step(r)};
  endtask

  // Loads an opcode at pc (and any block-load source bytes), then runs it.
  task automatic run_op(bit [15:0] op);
    if (!halted && op[15:12] == OP_MISC && op[7:0] == KK_LDM) begin
      for (int i = 0; i <= op[11:8]; i++) begin
        if (!mem_written[12'(ix + 16'(i))]) send(CMD_WRITE, 12'(ix + 16'(i)), 8'($urandom));
      end
    end
    if (!halted) begin
      send(CMD_WRITE, pc, op[15:8]);
      send(CMD_WRITE, pc + 12'd1, op[7:0]);
    end
    send(CMD_EXEC, 12'($urandom), 8'($urandom));
  endtask

  // A random opcode that never halts the core.
  function automatic bit [15:0] pick_op();
    bit [3:0]  x = 4'($urandom);
    bit [3:0]  y = 4'($urandom);
    bit [7:0]  kk = 8'($urandom);
    bit [11:0] nnn = 12'($urandom);
    bit        hit = $urandom_range(1);
    bit [7:0]  misc[7] = '{KK_GDT, KK_SDT, KK_SST, KK_ADI, KK_FNT, KK_BCD, KK_LDM};
    case ($urandom_range(17))
      0:  return {OP_SYS, 4'h0, KK_CLS};
      1:  return (sp > 0) ? {OP_SYS, 4'h0, KK_RET} : {OP_CALL, nnn};
      2:  return (sp < STK_DEPTH) ? {OP_CALL, nnn} : {OP_SYS, 4'h0, KK_RET};
      3:  return {OP_SEI, x, hit ? vreg[x] : kk};
      4:  return {OP_SNEI, x, hit ? vreg[x] : kk};
      5:  return {OP_SER, x, hit ? x : y, 4'($urandom)};
      6:  return {OP_LDI, x, kk};
      7:  return {OP_ADDI, x, kk};
      8:  return {OP_LDIX, nnn};
      9:  return {OP_JPV0, nnn};
      10: return {OP_RND, x, kk};
      11: return {OP_DRW, nnn};
      12: return {OP_JP, nnn};
      default: return {OP_MISC, x, misc[$urandom_range(6)]};
    endcase
  endfunction

  task automatic wait_idle();
    while (req_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_start(bit [11:0] val);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_start_address <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pc = val;
  endtask

  task automatic report(string field, int got, int want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the oldest pending request, holds it while stalled
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) void'(req_q.pop_front());
      if (in_valid && in_stall) begin
        // payload must stay put until taken
      end else if (req_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_command <= req_q[0].cmd;
        in_mem_address <= req_q[0].addr;
        in_mem_data <= req_q[0].data;
        in_random_bits <= req_q[0].rnd;
        in_view_register <= req_q[0].view;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: random stalls plus one long hold-off on demand
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_go) begin
      hold_go = 1'b0;
      hold_cnt = HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: every taken result against the oldest expectation
  always @(posedge clk) begin
    cpu_state_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_executed_opcode !== e.op) report("opcode", out_executed_opcode, e.op);
        if (out_program_counter !== e.pc) report("pc", out_program_counter, e.pc);
        if (out_index_value !== e.ix) report("index", out_index_value, e.ix);
        if (out_stack_level !== e.sp) report("stack level", out_stack_level, e.sp);
        if (out_delay_value !== e.dt) report("delay", out_delay_value, e.dt);
        if (out_sound_value !== e.st) report("sound", out_sound_value, e.st);
        if (out_register_value !== e.rv) report("register", out_register_value, e.rv);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    bit [15:0] directed[$];
    int ending;

    foreach (mem_written[i]) mem_written[i] = 1'b0;
    foreach (vreg[i]) vreg[i] = '0;
    sp = 0;
    pc = START_RESET;
    ix = '0;
    dtimer = '0;
    stimer = '0;
    halted = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, wrapping arithmetic and each non-halting opcode kind
    directed = '{16'h60FF, 16'h7001, 16'h3000, 16'h4000, 16'h501F, 16'h6AFF,
                 16'hFA15, 16'hFA18, 16'hF107, 16'hCFFF, 16'hAFFF, 16'hFA33,
                 16'hF265, 16'h6064, 16'hBFFF, 16'hF029, 16'hFA1E, 16'hD123,
                 16'h00E0, 16'h2ABC, 16'h00EE, 16'h1FFE, 16'h3000, 16'h0000};
    directed.delete(directed.size() - 1);
    foreach (directed[i]) run_op(directed[i]);

    // Random phases, each after writing a new start address
    for (int p = 0; p < 6; p++) begin
      write_start(p == 0 ? 12'hFFF : p == 1 ? 12'h000 : 12'($urandom));
      quiet = (p == 1);
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(9) == 0) send(CMD_WRITE, 12'($urandom), 8'($urandom));
        run_op(pick_op());
        if (p == 2 && n == 5) hold_go = 1'b1;
        if (p == 3 && n == 10) wait_idle();  // sender pause until drained
      end
    end
    quiet = 1'b0;

    // Finish with one halting case, then traffic into the halted core
    ending = $urandom_range(2);
    if (ending == 0) begin
      case ($urandom_range(4))
        0: run_op({OP_SYS, 12'($urandom_range(12'hDF, 1))});
        1: run_op({OP_ALU, 12'($urandom)});
        2: run_op({OP_SNER, 12'($urandom)});
        3: run_op({OP_KEY, 12'($urandom)});
        default: run_op({OP_MISC, 4'($urandom), 8'hFF});
      endcase
    end else if (ending == 1) begin
      while (sp > 0) run_op({OP_SYS, 4'h0, KK_RET});
      run_op({OP_SYS, 4'h0, KK_RET});
    end else begin
      while (sp < STK_DEPTH) run_op({OP_CALL, 12'($urandom)});
      run_op({OP_CALL, 12'($urandom)});
    end
    send(CMD_WRITE, 12'($urandom), 8'($urandom));
    send(CMD_EXEC, 12'($urandom), 8'($urandom));
    send(CMD_EXEC, 12'($urandom), 8'($urandom));

    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
